>>> hw/rtl/json_string_unescaper_macros.svh
// Assertion macros used by the unescaper top level
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// same-cycle implication, disabled in reset
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("unescaper assertion failed");

// next-cycle implication, disabled in reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("unescaper assertion failed");

`endif

>>> hw/rtl/jsu_pkg.sv
// Types, codes and helpers shared by the unescaper modules
package jsu_pkg;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
    localparam logic [3:0] ERR_UNTERM    = 4'd2;
    localparam logic [3:0] ERR_END_ESC   = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
    localparam logic [3:0] ERR_CTRL      = 4'd5;
    localparam logic [3:0] ERR_SHORT_HEX = 4'd6;
    localparam logic [3:0] ERR_NON_HEX   = 4'd7;
    localparam logic [3:0] ERR_UNPAIRED  = 4'd8;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd9;
    localparam logic [3:0] ERR_MAX       = ERR_LONE_LOW;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // classified input beat
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
        logic       is_quote;
        logic       is_bslash;
        logic       is_ctrl;
        logic       is_u;
        logic       hex_ok;
        logic [3:0] nib;
        logic       esc_ok;
        logic [7:0] esc_byte;
    } t_beat;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
    } t_utf8;

    function automatic t_utf8 utf8_pack(input logic [20:0] cp);
        t_utf8 r;
        r.bytes = 32'd0;
        r.count = 3'd0;
        if (cp < 21'h80) begin
            r.count = 3'd1;
            r.bytes = {24'd0, 1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            r.count = 3'd2;
            r.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp < 21'h10000) begin
            r.count = 3'd3;
            r.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            r.count = 3'd4;
            r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/json_string_unescaper.sv
// Top level of the JSON string literal unescaper (bytes in, UTF-8 out)
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+---------------------------------------------
//  input    | i_valid | o_ready | i_kind, i_in_byte
//  result   | o_valid | i_ready | o_out_bytes, o_out_count, o_done_res,
//           |         |         | o_error_code
//
// One input beat per cycle while the queue is not full; a result passes the queue and then the result register.
// The back end retires one queued beat per cycle while its result register
// is empty or being drained; the queue depth sets how long the input side
// can run on while the result side stalls.
// Synchronous active-low reset empties the queue and returns to waiting for
// an opening quote.
`include "json_string_unescaper_macros.svh"

module json_string_unescaper import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_bytes,
    output logic [2:0]  o_out_count,
    output logic        o_done_res,
    output logic [3:0]  o_error_code
);

    logic  q_full;
    logic  q_nempty;
    logic  push;
    logic  pop;
    t_beat f_beat;
    t_beat q_beat;

    jsu_front u_front (
        .i_valid   (i_valid),
        .i_kind    (i_kind),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_beat    (f_beat)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_beat   (f_beat),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_beat   (q_beat)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nempty     (q_nempty),
        .i_beat       (q_beat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_bytes  (o_out_bytes),
        .o_out_count  (o_out_count),
        .o_done_res   (o_done_res),
        .o_error_code (o_error_code)
    );

    `JSU_ASSERT_NOW(a_end_no_bytes, o_valid && (o_done_res || (o_error_code != ERR_NONE)), (o_out_count == 3'd0) && (o_out_bytes == 32'd0))
    `JSU_ASSERT_NOW(a_bytes_clean, o_valid && (o_out_count != 3'd0), !o_done_res && (o_error_code == ERR_NONE) && (o_out_count <= 3'd4))
    `JSU_ASSERT_NOW(a_err_range, o_valid, (o_error_code <= ERR_MAX) && !(o_done_res && (o_error_code != ERR_NONE)))
    `JSU_ASSERT_NEXT(a_pop_fills, pop && !(o_valid && !i_ready) && !q_beat.is_end && (q_beat.data < CH_SPACE) && !q_beat.is_quote, o_valid || !$past(o_valid) || $past(i_ready))

endmodule

>>> hw/rtl/jsu_front.sv
// Front end: accept input beats and classify each byte
module jsu_front import jsu_pkg::*; (
    input  logic       i_valid,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_beat      o_beat
);

    logic [7:0] b;

    assign b       = i_in_byte;
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_beat           = '0;
        o_beat.is_end    = i_kind;
        o_beat.data      = b;
        o_beat.is_quote  = (b == CH_QUOTE);
        o_beat.is_bslash = (b == CH_BSLASH);
        o_beat.is_ctrl   = (b < CH_SPACE);
        o_beat.is_u      = (b == CH_U);
        if (b inside {[8'h30:8'h39]}) begin
            o_beat.hex_ok = 1'b1;
            o_beat.nib    = b[3:0];
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            o_beat.hex_ok = 1'b1;
            o_beat.nib    = 4'(b[2:0] + 3'd1) + 4'd8;
        end
        o_beat.esc_ok = 1'b1;
        case (b)
            CH_QUOTE:  o_beat.esc_byte = CH_QUOTE;
            CH_BSLASH: o_beat.esc_byte = CH_BSLASH;
            CH_SLASH:  o_beat.esc_byte = CH_SLASH;
            8'h62:     o_beat.esc_byte = 8'h08;
            8'h66:     o_beat.esc_byte = 8'h0C;
            8'h6E:     o_beat.esc_byte = 8'h0A;
            8'h72:     o_beat.esc_byte = 8'h0D;
            8'h74:     o_beat.esc_byte = 8'h09;
            default: begin
                o_beat.esc_ok   = 1'b0;
                o_beat.esc_byte = 8'h00;
            end
        endcase
    end

endmodule

>>> hw/rtl/jsu_queue.sv
// Short queue of classified beats between front and back
module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_beat i_beat,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nempty,
    output t_beat o_beat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_beat         r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_beat   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

endmodule

>>> hw/rtl/jsu_back.sv
// Back end: literal state machine, escape decoding and result register
module jsu_back import jsu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nempty,
    input  t_beat       i_beat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_bytes,
    output logic [2:0]  o_out_count,
    output logic        o_done_res,
    output logic [3:0]  o_error_code
);

    localparam logic [2:0] M_WAIT = 3'd0;
    localparam logic [2:0] M_STR  = 3'd1;
    localparam logic [2:0] M_ESC  = 3'd2;
    localparam logic [2:0] M_HEX  = 3'd3;
    localparam logic [2:0] M_PBS  = 3'd4;
    localparam logic [2:0] M_PU   = 3'd5;
    localparam logic [2:0] M_LHEX = 3'd6;

    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_hc, n_hc;
    logic [15:0] r_hv, n_hv;
    logic [9:0]  r_hh, n_hh;

    logic        r_valid;
    logic [31:0] r_bytes;
    logic [2:0]  r_count;
    logic        r_done;
    logic [3:0]  r_err;

    logic        fire;
    logic        emit;
    logic        e_done;
    logic [3:0]  e_err;
    t_utf8       e_data;
    logic [15:0] hv_shift;
    logic [20:0] cp_pair;

    assign fire     = i_nempty && (!r_valid || i_ready);
    assign o_pop    = fire;
    assign hv_shift = {r_hv[11:0], i_beat.nib};
    assign cp_pair  = 21'h10000 + {1'b0, r_hh, hv_shift[9:0]};

    always_comb begin
        n_mode = r_mode;
        n_hc   = r_hc;
        n_hv   = r_hv;
        n_hh   = r_hh;
        emit   = 1'b0;
        e_done = 1'b0;
        e_err  = ERR_NONE;
        e_data = '0;
        case (r_mode)
            M_STR: begin
                if (i_beat.is_end) begin
                    e_err = ERR_UNTERM;
                end else if (i_beat.is_quote) begin
                    n_mode = M_WAIT;
                    e_done = 1'b1;
                end else if (i_beat.is_bslash) begin
                    n_mode = M_ESC;
                end else if (i_beat.is_ctrl) begin
                    e_err = ERR_CTRL;
                end else begin
                    emit         = 1'b1;
                    e_data.bytes = {24'd0, i_beat.data};
                    e_data.count = 3'd1;
                end
            end
            M_ESC: begin
                if (i_beat.is_end) begin
                    e_err = ERR_END_ESC;
                end else if (i_beat.esc_ok) begin
                    n_mode       = M_STR;
                    emit         = 1'b1;
                    e_data.bytes = {24'd0, i_beat.esc_byte};
                    e_data.count = 3'd1;
                end else if (i_beat.is_u) begin
                    n_mode = M_HEX;
                    n_hc   = 2'd0;
                    n_hv   = 16'd0;
                end else begin
                    e_err = ERR_BAD_ESC;
                end
            end
            M_HEX, M_LHEX: begin
                if (i_beat.is_end) begin
                    e_err = ERR_SHORT_HEX;
                end else if (!i_beat.hex_ok) begin
                    e_err = ERR_NON_HEX;
                end else begin
                    n_hv = hv_shift;
                    if (r_hc != 2'd3) begin
                        n_hc = r_hc + 2'd1;
                    end else begin
                        n_hc = 2'd0;
                        if (r_mode == M_HEX) begin
                            if (hv_shift inside {[16'hD800:16'hDBFF]}) begin
                                n_hh   = hv_shift[9:0];
                                n_mode = M_PBS;
                            end else if (hv_shift inside {[16'hDC00:16'hDFFF]}) begin
                                e_err = ERR_LONE_LOW;
                            end else begin
                                n_mode = M_STR;
                                emit   = 1'b1;
                                e_data = utf8_pack({5'd0, hv_shift});
                            end
                        end else begin
                            if (hv_shift inside {[16'hDC00:16'hDFFF]}) begin
                                n_mode = M_STR;
                                emit   = 1'b1;
                                e_data = utf8_pack(cp_pair);
                            end else begin
                                e_err = ERR_UNPAIRED;
                            end
                        end
                    end
                end
            end
            M_PBS: begin
                if (i_beat.is_end || !i_beat.is_bslash) begin
                    e_err = ERR_UNPAIRED;
                end else begin
                    n_mode = M_PU;
                end
            end
            M_PU: begin
                if (i_beat.is_end || !i_beat.is_u) begin
                    e_err = ERR_UNPAIRED;
                end else begin
                    n_mode = M_LHEX;
                    n_hc   = 2'd0;
                    n_hv   = 16'd0;
                end
            end
            default: begin
                n_mode = M_WAIT;
                if (!i_beat.is_end) begin
                    if (i_beat.is_quote) begin
                        n_mode = M_STR;
                    end else begin
                        e_err = ERR_NO_QUOTE;
                    end
                end
            end
        endcase
        if (e_err != ERR_NONE) begin
            n_mode = M_WAIT;
            n_hc   = 2'd0;
            n_hv   = 16'd0;
            e_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_WAIT;
            r_hc    <= 2'd0;
            r_hv    <= 16'd0;
            r_hh    <= 10'd0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mode <= n_mode;
                r_hc   <= n_hc;
                r_hv   <= n_hv;
                r_hh   <= n_hh;
            end
            if (fire && (emit || e_done || (e_err != ERR_NONE))) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (emit || e_done || (e_err != ERR_NONE))) begin
            r_bytes <= e_data.bytes;
            r_count <= e_data.count;
            r_done  <= e_done;
            r_err   <= e_err;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_bytes  = r_bytes;
    assign o_out_count  = r_count;
    assign o_done_res   = r_done;
    assign o_error_code = r_err;

endmodule
